// ===== design/wavhp_pkg.sv =====
// shared types and constants for the wave header parser
// no dependencies
package wavhp_pkg;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_HEAD,
        PH_EXT,
        PH_SKIP,
        PH_DTAG,
        PH_DSIZE
    } phase_t;

    localparam logic [3:0] ST_VALID     = 4'd0;
    localparam logic [3:0] ST_RIFF      = 4'd1;
    localparam logic [3:0] ST_WAVE      = 4'd2;
    localparam logic [3:0] ST_FMT_ID    = 4'd3;
    localparam logic [3:0] ST_TAG       = 4'd4;
    localparam logic [3:0] ST_CHANNELS  = 4'd5;
    localparam logic [3:0] ST_RATE      = 4'd6;
    localparam logic [3:0] ST_BITS      = 4'd7;
    localparam logic [3:0] ST_EXTRA     = 4'd8;
    localparam logic [3:0] ST_FACT      = 4'd9;
    localparam logic [3:0] ST_DATA_ID   = 4'd10;
    localparam logic [3:0] ST_SIZE      = 4'd11;
    localparam logic [3:0] ST_TRUNCATED = 4'd12;

    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
    localparam logic [31:0] TAG_FACT = 32'h7463_6166;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;

    localparam logic [31:0] FMT_LEN_PLAIN = 32'h10;
    localparam logic [31:0] OFFSET_FMT    = 32'd36;
    localparam logic [31:0] OFFSET_FACT   = 32'd46;
    localparam logic [31:0] TAG_BYTES     = 32'd4;

    localparam logic [1:0] REG_MIN_RATE  = 2'd0;
    localparam logic [1:0] REG_MAX_RATE  = 2'd1;
    localparam logic [1:0] REG_TIMER_HZ  = 2'd2;
    localparam logic [1:0] REG_MAX_DATA  = 2'd3;

    localparam logic [31:0] RST_MIN_RATE = 32'd8000;
    localparam logic [31:0] RST_MAX_RATE = 32'd50000;
    localparam logic [31:0] RST_TIMER_HZ = 32'd48000000;
    localparam logic [31:0] RST_MAX_DATA = 32'd50000;

    localparam int QDEPTH = 2;

    typedef struct packed {
        logic [7:0] data;
        logic       start;
        logic       last;
    } item_t;

    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [31:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [31:0] quotient;
    } div_rsp_t;

endpackage

// ===== design/wavhp_front.sv =====
// input side: accepts bytes and queues them for the parser
// depends on wavhp_pkg
module wavhp_front
    import wavhp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] header_byte,
    input  logic       file_start,
    input  logic       file_end,
    output logic       q_valid,
    output item_t      q_item,
    input  logic       q_pop
);

    item_t      mem_reg [QDEPTH];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push;
    logic       pop;

    assign in_ready = (count_reg != 2'(QDEPTH));
    assign push     = in_valid && in_ready;
    assign q_valid  = (count_reg != 2'd0);
    assign pop      = q_pop && q_valid;
    assign q_item   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= '{data: header_byte, start: file_start, last: file_end};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== design/wavhp_div.sv =====
// radix-2 restoring divider, one quotient bit per cycle
// depends on wavhp_pkg
module wavhp_div
    import wavhp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [32:0] rem_reg, rem_next;
    logic [31:0] quo_reg, quo_next;
    logic [31:0] dsr_reg, dsr_next;
    logic [32:0] trial;
    logic [32:0] diff;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        trial     = {rem_reg[31:0], quo_reg[31]};
        diff      = trial - {1'b0, dsr_reg};
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = 5'd0;
            rem_next  = '0;
            quo_next  = req.dividend;
            dsr_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            if (!diff[32])
            begin
                rem_next = diff;
                quo_next = {quo_reg[30:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                quo_next = {quo_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd31)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 5'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    assign rsp = '{busy: busy_reg, done: done_reg, quotient: quo_reg};

endmodule

// ===== design/wavhp_back.sv =====
// parse sequencer: checks header words in file order and holds the result
// depends on wavhp_pkg
module wavhp_back
    import wavhp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_valid,
    input  item_t       q_item,
    output logic        q_pop,
    input  logic [31:0] min_rate,
    input  logic [31:0] max_rate,
    input  logic [31:0] timer_hz,
    input  logic [31:0] max_data,
    output div_req_t    div_req,
    input  div_rsp_t    div_rsp,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [3:0]  status,
    output logic [31:0] sample_rate,
    output logic [31:0] byte_rate,
    output logic [15:0] block_align,
    output logic [15:0] bits_per_sample,
    output logic [31:0] data_bytes,
    output logic [31:0] data_offset,
    output logic [31:0] timer_reload
);

    phase_t      phase_reg, phase_next;
    logic [5:0]  pos_reg, pos_next;
    logic [31:0] shift_reg, shift_next;
    logic        ext_reg, ext_next;
    logic [31:0] skip_reg, skip_next;
    logic [31:0] rate_reg, rate_next;
    logic [31:0] brate_reg, brate_next;
    logic [15:0] align_reg, align_next;
    logic [15:0] bits_reg, bits_next;
    logic [31:0] off_reg, off_next;
    logic [31:0] reload_reg;

    logic        ovalid_reg;
    logic        owait_reg;
    logic [3:0]  ost_reg;
    logic [31:0] orate_reg, obrate_reg, odata_reg, ooff_reg, oreload_reg;
    logic [15:0] oalign_reg, obits_reg;

    logic        active;
    logic        emit;
    logic [3:0]  st;
    logic [31:0] data;
    logic [31:0] acc;
    logic [15:0] half;
    logic        start_div;
    logic        stall;
    logic        consume;

    always_comb
    begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        shift_next = shift_reg;
        ext_next   = ext_reg;
        skip_next  = skip_reg;
        rate_next  = rate_reg;
        brate_next = brate_reg;
        align_next = align_reg;
        bits_next  = bits_reg;
        off_next   = off_reg;
        active     = (phase_reg != PH_IDLE);
        emit       = 1'b0;
        st         = ST_VALID;
        data       = '0;
        start_div  = 1'b0;
        if (q_item.start)
        begin
            phase_next = PH_HEAD;
            pos_next   = '0;
            shift_next = '0;
            ext_next   = 1'b0;
            skip_next  = '0;
            rate_next  = '0;
            brate_next = '0;
            align_next = '0;
            bits_next  = '0;
            off_next   = '0;
            active     = 1'b1;
        end
        acc  = {q_item.data, shift_next[31:8]};
        half = acc[31:16];
        shift_next = acc;
        case (phase_next)
            PH_HEAD:
            begin
                case (pos_next)
                    6'd3:  if (acc != TAG_RIFF) begin emit = 1'b1; st = ST_RIFF; end
                    6'd11: if (acc != TAG_WAVE) begin emit = 1'b1; st = ST_WAVE; end
                    6'd15: if (acc != TAG_FMT) begin emit = 1'b1; st = ST_FMT_ID; end
                    6'd19: ext_next = (acc != FMT_LEN_PLAIN);
                    6'd21: if (half != 16'd1) begin emit = 1'b1; st = ST_TAG; end
                    6'd23: if (half != 16'd1) begin emit = 1'b1; st = ST_CHANNELS; end
                    6'd27:
                    begin
                        rate_next = acc;
                        if (acc < min_rate || acc > max_rate)
                        begin
                            emit = 1'b1;
                            st   = ST_RATE;
                        end
                        else
                        begin
                            start_div = 1'b1;
                        end
                    end
                    6'd31: brate_next = acc;
                    6'd33: align_next = half;
                    6'd35:
                    begin
                        bits_next = half;
                        if (half != 16'd8 && half != 16'd16)
                        begin
                            emit = 1'b1;
                            st   = ST_BITS;
                        end
                        else
                        begin
                            off_next = OFFSET_FMT;
                            if (ext_next)
                            begin
                                phase_next = PH_EXT;
                            end
                            else
                            begin
                                phase_next = PH_DTAG;
                            end
                        end
                    end
                    default:
                    begin
                    end
                endcase
                if (phase_next == PH_DTAG)
                begin
                    pos_next = '0;
                end
                else
                begin
                    pos_next = pos_next + 6'd1;
                end
            end
            PH_EXT:
            begin
                case (pos_next)
                    6'd37: if (half != 16'd0) begin emit = 1'b1; st = ST_EXTRA; end
                    6'd41: if (acc != TAG_FACT) begin emit = 1'b1; st = ST_FACT; end
                    6'd45:
                    begin
                        off_next   = OFFSET_FACT + acc;
                        skip_next  = acc;
                        phase_next = (acc != '0) ? PH_SKIP : PH_DTAG;
                    end
                    default:
                    begin
                    end
                endcase
                if (phase_next == PH_EXT)
                begin
                    pos_next = pos_next + 6'd1;
                end
                else
                begin
                    pos_next = '0;
                end
            end
            PH_SKIP:
            begin
                skip_next = skip_next - 32'd1;
                if (skip_next == '0)
                begin
                    phase_next = PH_DTAG;
                    pos_next   = '0;
                end
            end
            PH_DTAG:
            begin
                if (pos_next == 6'd3)
                begin
                    off_next = off_next + TAG_BYTES;
                    if (acc != TAG_DATA)
                    begin
                        emit = 1'b1;
                        st   = ST_DATA_ID;
                    end
                    else
                    begin
                        phase_next = PH_DSIZE;
                        pos_next   = '0;
                    end
                end
                else
                begin
                    pos_next = pos_next + 6'd1;
                end
            end
            PH_DSIZE:
            begin
                if (pos_next == 6'd3)
                begin
                    emit = 1'b1;
                    if (acc > max_data)
                    begin
                        st = ST_SIZE;
                    end
                    else
                    begin
                        off_next = off_next + TAG_BYTES;
                        data     = acc;
                        st       = ST_VALID;
                    end
                end
                else
                begin
                    pos_next = pos_next + 6'd1;
                end
            end
            default:
            begin
                active = 1'b0;
            end
        endcase
        if (!emit && q_item.last)
        begin
            emit = 1'b1;
            st   = ST_TRUNCATED;
        end
        if (emit)
        begin
            phase_next = PH_IDLE;
        end
        emit      = emit && active;
        start_div = start_div && active;
    end

    assign stall   = active && ((q_item.start && (div_rsp.busy || div_rsp.done))
                             || (emit && ovalid_reg));
    assign consume = q_valid && !stall;
    assign q_pop   = consume;

    assign div_req = '{start: consume && start_div, dividend: timer_hz, divisor: acc};

    always_ff @(posedge clk)
    begin
        if (consume && emit)
        begin
            ost_reg    <= st;
            orate_reg  <= rate_next;
            obrate_reg <= brate_next;
            oalign_reg <= align_next;
            obits_reg  <= bits_next;
            odata_reg  <= data;
            ooff_reg   <= off_next;
        end
        if (div_rsp.done && (owait_reg || (consume && emit)))
        begin
            oreload_reg <= div_rsp.quotient - 32'd1;
        end
        else if (consume && emit)
        begin
            oreload_reg <= q_item.start ? '0 : reload_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            pos_reg    <= '0;
            shift_reg  <= '0;
            ext_reg    <= 1'b0;
            skip_reg   <= '0;
            rate_reg   <= '0;
            brate_reg  <= '0;
            align_reg  <= '0;
            bits_reg   <= '0;
            off_reg    <= '0;
            reload_reg <= '0;
            ovalid_reg <= 1'b0;
            owait_reg  <= 1'b0;
        end
        else
        begin
            if (consume && active)
            begin
                phase_reg <= phase_next;
                pos_reg   <= pos_next;
                shift_reg <= shift_next;
                ext_reg   <= ext_next;
                skip_reg  <= skip_next;
                rate_reg  <= rate_next;
                brate_reg <= brate_next;
                align_reg <= align_next;
                bits_reg  <= bits_next;
                off_reg   <= off_next;
            end
            if (div_rsp.done)
            begin
                reload_reg <= div_rsp.quotient - 32'd1;
            end
            else if (consume && q_item.start)
            begin
                reload_reg <= '0;
            end
            if (consume && emit)
            begin
                ovalid_reg <= 1'b1;
                owait_reg  <= div_rsp.busy || start_div;
            end
            else
            begin
                if (out_valid && out_ready)
                begin
                    ovalid_reg <= 1'b0;
                end
                if (div_rsp.done)
                begin
                    owait_reg <= 1'b0;
                end
            end
        end
    end

    assign out_valid       = ovalid_reg && !owait_reg;
    assign status          = ost_reg;
    assign sample_rate     = orate_reg;
    assign byte_rate       = obrate_reg;
    assign block_align     = oalign_reg;
    assign bits_per_sample = obits_reg;
    assign data_bytes      = odata_reg;
    assign data_offset     = ooff_reg;
    assign timer_reload    = oreload_reg;

endmodule

// ===== design/wav_header_parser.sv =====
// wave header parser top level: config registers, input queue, parser, divider
// one byte per cycle when no result is pending; a result is offered the cycle after the parser
// takes its last byte, which with an empty queue first passes through the input queue register
// timer reload comes from a serial divider started by the rate field;
// a result or a new file start that arrives while it runs waits for it
// async active-low reset clears all control state and restores register defaults
module wav_header_parser
    import wavhp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  header_byte,
    input  logic        file_start,
    input  logic        file_end,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [3:0]  status,
    output logic [31:0] sample_rate,
    output logic [31:0] byte_rate,
    output logic [15:0] block_align,
    output logic [15:0] bits_per_sample,
    output logic [31:0] data_bytes,
    output logic [31:0] data_offset,
    output logic [31:0] timer_reload,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    logic [31:0] min_rate_reg, max_rate_reg, timer_hz_reg, max_data_reg;
    logic        q_valid;
    item_t       q_item;
    logic        q_pop;
    div_req_t    div_req;
    div_rsp_t    div_rsp;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_rate_reg <= RST_MIN_RATE;
            max_rate_reg <= RST_MAX_RATE;
            timer_hz_reg <= RST_TIMER_HZ;
            max_data_reg <= RST_MAX_DATA;
        end
        else if (cfg_valid && cfg_index[7:2] == 6'd0)
        begin
            case (cfg_index[1:0])
                REG_MIN_RATE: min_rate_reg <= cfg_data;
                REG_MAX_RATE: max_rate_reg <= cfg_data;
                REG_TIMER_HZ: timer_hz_reg <= cfg_data;
                REG_MAX_DATA: max_data_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    wavhp_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .header_byte (header_byte),
        .file_start  (file_start),
        .file_end    (file_end),
        .q_valid     (q_valid),
        .q_item      (q_item),
        .q_pop       (q_pop)
    );

    wavhp_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    wavhp_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .q_valid         (q_valid),
        .q_item          (q_item),
        .q_pop           (q_pop),
        .min_rate        (min_rate_reg),
        .max_rate        (max_rate_reg),
        .timer_hz        (timer_hz_reg),
        .max_data        (max_data_reg),
        .div_req         (div_req),
        .div_rsp         (div_rsp),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .status          (status),
        .sample_rate     (sample_rate),
        .byte_rate       (byte_rate),
        .block_align     (block_align),
        .bits_per_sample (bits_per_sample),
        .data_bytes      (data_bytes),
        .data_offset     (data_offset),
        .timer_reload    (timer_reload)
    );

endmodule
